@@ sv/modbus_rtu_master_transaction_defines.svh @@
// Assertion macros shared by the Modbus RTU master transaction design.
`ifndef MODBUS_RTU_MASTER_TRANSACTION_DEFINES_SVH
`define MODBUS_RTU_MASTER_TRANSACTION_DEFINES_SVH

`ifndef SYNTHESIS

// Same-cycle implication, checked only out of reset.
`define MBM_ASSERT_NOW(lbl, clk, rstn, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
    else $error("mbm assertion failed");

// Next-cycle implication, checked only out of reset.
`define MBM_ASSERT_NEXT(lbl, clk, rstn, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
    else $error("mbm assertion failed");

`else

`define MBM_ASSERT_NOW(lbl, clk, rstn, ante, cons)
`define MBM_ASSERT_NEXT(lbl, clk, rstn, ante, cons)

`endif

`endif

@@ sv/mbm_pkg.sv @@
// Types, codes and the CRC-16 step shared by the Modbus RTU master modules.
package mbm_pkg;

  // Input action codes.
  localparam logic [2:0] ACT_REQ_BYTE = 3'd0;
  localparam logic [2:0] ACT_TX_READY = 3'd1;
  localparam logic [2:0] ACT_RX_BYTE  = 3'd2;
  localparam logic [2:0] ACT_TICK     = 3'd3;
  localparam logic [2:0] ACT_POLL     = 3'd4;

  // Result kinds.
  localparam logic [2:0] KIND_NONE  = 3'd0;
  localparam logic [2:0] KIND_TX    = 3'd1;
  localparam logic [2:0] KIND_BUSY  = 3'd2;
  localparam logic [2:0] KIND_DATA  = 3'd3;
  localparam logic [2:0] KIND_TIMES = 3'd4;

  // Transaction phases.
  localparam logic [2:0] PH_IDLE     = 3'd0;
  localparam logic [2:0] PH_TX       = 3'd1;
  localparam logic [2:0] PH_TXDONE   = 3'd2;
  localparam logic [2:0] PH_RX       = 3'd3;
  localparam logic [2:0] PH_CHECK    = 3'd4;
  localparam logic [2:0] PH_EXEC     = 3'd5;
  localparam logic [2:0] PH_RXERR    = 3'd6;
  localparam logic [2:0] PH_TIMESERR = 3'd7;

  // Register indexes on the configuration port.
  localparam logic [1:0] REG_TIMEOUT   = 2'd0;
  localparam logic [1:0] REG_ERR_LIMIT = 2'd1;
  localparam logic [1:0] REG_MIN_BYTES = 2'd2;

  localparam logic [15:0] CRC_INIT = 16'hFFFF;
  localparam logic [15:0] CRC_POLY = 16'hA001;
  localparam logic [7:0]  FC_MULTI_COILS = 8'd15;
  localparam logic [7:0]  FC_MULTI_REGS  = 8'd16;
  localparam logic [7:0]  ERR_SAT        = 8'hFF;

  // A classified request from the front end.
  typedef struct packed {
    logic       is_req;
    logic       is_txr;
    logic       is_rx;
    logic       is_tick;
    logic       is_poll;
    logic [7:0] byte_value;
    logic       frame_end;
  } item_t;

  // Configuration register values.
  typedef struct packed {
    logic [7:0] timeout;
    logic [7:0] err_limit;
    logic [6:0] min_bytes;
  } cfg_t;

  // One result item.
  typedef struct packed {
    logic [2:0] kind;
    logic [7:0] out_byte;
    logic [7:0] slave_address;
    logic [7:0] function_code;
    logic       last_out;
    logic [2:0] machine_state;
  } res_t;

  // Feed one byte into the Modbus CRC-16.
  function automatic logic [15:0] crc_feed(input logic [15:0] crc, input logic [7:0] b);
    logic [15:0] c;
    c = crc ^ {8'h00, b};
    for (int i = 0; i < 8; i++) begin
      c = c[0] ? ((c >> 1) ^ CRC_POLY) : (c >> 1);
    end
    return c;
  endfunction

endpackage

@@ sv/mbm_front.sv @@
// Front end: accepts requests, classifies the action and queues them for the back end.
module mbm_front
  import mbm_pkg::*;
(
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  output logic       in_stall,
  input  logic [2:0] in_action,
  input  logic [7:0] in_byte_value,
  input  logic       in_frame_end,
  output logic       q_valid,
  output item_t      q_item,
  input  logic       q_pop
);

  item_t       slot_r [2];
  logic        wp_r, wp_nxt;
  logic        rp_r, rp_nxt;
  logic [1:0]  cnt_r, cnt_nxt;
  item_t       cls;
  logic        push;

  // Decode the action; codes with no meaning leave every flag low.
  always_comb begin
    cls.is_req     = (in_action == ACT_REQ_BYTE);
    cls.is_txr     = (in_action == ACT_TX_READY);
    cls.is_rx      = (in_action == ACT_RX_BYTE);
    cls.is_tick    = (in_action == ACT_TICK);
    cls.is_poll    = (in_action == ACT_POLL);
    cls.byte_value = in_byte_value;
    cls.frame_end  = in_frame_end;
  end

  // Requests with an undefined action code are accepted and dropped here.
  assign in_stall = (cnt_r == 2'd2);
  assign push     = in_valid && !in_stall &&
                    (cls.is_req || cls.is_txr || cls.is_rx || cls.is_tick || cls.is_poll);
  assign q_valid  = (cnt_r != 2'd0);
  assign q_item   = slot_r[rp_r];

  // Queue pointers and fill count.
  always_comb begin
    wp_nxt  = wp_r ^ push;
    rp_nxt  = rp_r ^ q_pop;
    cnt_nxt = cnt_r + {1'b0, push} - {1'b0, q_pop};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r  <= 1'b0;
      rp_r  <= 1'b0;
      cnt_r <= 2'd0;
    end else begin
      wp_r  <= wp_nxt;
      rp_r  <= rp_nxt;
      cnt_r <= cnt_nxt;
    end
  end

  // Queue storage.
  always_ff @(posedge clk) begin
    if (push) begin
      slot_r[wp_r] <= cls;
    end
  end

endmodule

@@ sv/mbm_back.sv @@
// Back end: runs the transaction, holds the frame stores and drives the result register.
module mbm_back
  import mbm_pkg::*;
#(
  parameter int MAX_FRAME = 64
) (
  input  logic  clk,
  input  logic  rst_n,
  input  cfg_t  cfg,
  input  logic  q_valid,
  input  item_t q_item,
  output logic  q_pop,
  output logic  out_valid,
  input  logic  out_stall,
  output res_t  out_res
);

  localparam int AW = $clog2(MAX_FRAME);
  localparam int CW = $clog2(MAX_FRAME + 1);

  localparam logic [2:0] SQ_IDLE   = 3'd0;
  localparam logic [2:0] SQ_CRCLO  = 3'd1;
  localparam logic [2:0] SQ_CRCHI  = 3'd2;
  localparam logic [2:0] SQ_TXRD   = 3'd3;
  localparam logic [2:0] SQ_TXOUT  = 3'd4;
  localparam logic [2:0] SQ_DLVRD  = 3'd5;
  localparam logic [2:0] SQ_DLVOUT = 3'd6;

  logic [2:0]    seq_r, seq_nxt;
  logic [2:0]    phase_r, phase_nxt;
  logic [CW-1:0] len_r, len_nxt;
  logic [CW-1:0] sent_r, sent_nxt;
  logic [CW-1:0] cnt_r, cnt_nxt;
  logic [CW-1:0] k_r, k_nxt;
  logic [CW-1:0] kend_r, kend_nxt;
  logic [15:0]   crc_r, crc_nxt;
  logic [7:0]    err_r, err_nxt;
  logic [7:0]    wait_r, wait_nxt;
  logic [7:0]    req0_r, req0_nxt, req1_r, req1_nxt;
  logic [7:0]    rep0_r, rep0_nxt, rep1_r, rep1_nxt;

  logic [7:0]    req_mem [MAX_FRAME];
  logic [7:0]    rep_mem [MAX_FRAME];
  logic [7:0]    req_rd_r, rep_rd_r;
  logic          req_we, rep_we;
  logic [AW-1:0] req_waddr, rep_waddr;
  logic [7:0]    req_wdata, rep_wdata;

  logic          out_vld_r, out_vld_nxt;
  res_t          out_res_r;
  logic          out_free, emit;
  res_t          emit_res;

  logic [15:0]   crc_base, crc_fed;
  logic [7:0]    wait_inc, err_inc;
  logic          reply_ok, fc_data;

  assign out_free  = !out_vld_r || !out_stall;
  assign q_pop     = q_valid && (seq_r == SQ_IDLE) && out_free;
  assign out_valid = out_vld_r;
  assign out_res   = out_res_r;

  // Helper values for the byte and poll handling.
  always_comb begin
    crc_base = (len_r == '0) ? CRC_INIT : crc_r;
    crc_fed  = crc_feed((q_item.is_rx && phase_r == PH_TXDONE) ? CRC_INIT :
                        (q_item.is_rx ? crc_r : crc_base), q_item.byte_value);
    wait_inc = wait_r + 8'd1;
    err_inc  = (err_r == ERR_SAT) ? ERR_SAT : (err_r + 8'd1);
    reply_ok = (cnt_r >= CW'(2)) && (8'(cnt_r) >= {1'b0, cfg.min_bytes}) &&
               (crc_r == 16'h0000) && (rep0_r == req0_r) && (rep1_r == req1_r);
    fc_data  = ((rep1_r >= 8'd1) && (rep1_r <= 8'd6)) ||
               (rep1_r == FC_MULTI_COILS) || (rep1_r == FC_MULTI_REGS);
  end

  // Transaction sequencer.
  always_comb begin
    seq_nxt   = seq_r;
    phase_nxt = phase_r;
    len_nxt   = len_r;
    sent_nxt  = sent_r;
    cnt_nxt   = cnt_r;
    k_nxt     = k_r;
    kend_nxt  = kend_r;
    crc_nxt   = crc_r;
    err_nxt   = err_r;
    wait_nxt  = wait_r;
    req0_nxt  = req0_r;
    req1_nxt  = req1_r;
    rep0_nxt  = rep0_r;
    rep1_nxt  = rep1_r;
    req_we    = 1'b0;
    req_waddr = len_r[AW-1:0];
    req_wdata = q_item.byte_value;
    rep_we    = 1'b0;
    rep_waddr = cnt_r[AW-1:0];
    rep_wdata = q_item.byte_value;
    emit      = 1'b0;
    emit_res  = '0;

    case (seq_r)
      SQ_IDLE: begin
        if (q_pop) begin
          if (q_item.is_req) begin
            if (phase_r != PH_IDLE) begin
              // Busy reject.
              emit                   = 1'b1;
              emit_res.kind          = KIND_BUSY;
              emit_res.last_out      = 1'b1;
              emit_res.machine_state = phase_r;
            end else begin
              crc_nxt = crc_base;
              if (len_r < CW'(MAX_FRAME - 2)) begin
                req_we  = 1'b1;
                len_nxt = len_r + CW'(1);
                crc_nxt = crc_fed;
              end
              if (q_item.frame_end) begin
                seq_nxt = SQ_CRCLO;
              end
            end
          end else if (q_item.is_txr) begin
            if (phase_r == PH_TX) begin
              if (sent_r >= len_r) begin
                phase_nxt = PH_TXDONE;
                wait_nxt  = 8'd0;
              end else begin
                seq_nxt = SQ_TXRD;
              end
            end
          end else if (q_item.is_rx) begin
            if (phase_r == PH_TXDONE) begin
              rep_we    = 1'b1;
              rep_waddr = '0;
              cnt_nxt   = CW'(1);
              crc_nxt   = crc_fed;
              phase_nxt = PH_RX;
            end else if (phase_r == PH_RX && cnt_r < CW'(MAX_FRAME)) begin
              rep_we  = 1'b1;
              cnt_nxt = cnt_r + CW'(1);
              crc_nxt = crc_fed;
            end
          end else if (q_item.is_tick) begin
            if (phase_r == PH_TXDONE) begin
              if (wait_inc >= cfg.timeout) begin
                wait_nxt  = 8'd0;
                phase_nxt = PH_RXERR;
              end else begin
                wait_nxt = wait_inc;
              end
            end else if (phase_r == PH_RX) begin
              phase_nxt = PH_CHECK;
            end
          end else if (q_item.is_poll) begin
            case (phase_r)
              PH_CHECK: begin
                phase_nxt = reply_ok ? PH_EXEC : PH_RXERR;
              end
              PH_RXERR: begin
                err_nxt = err_inc;
                if (err_inc >= cfg.err_limit) begin
                  phase_nxt = PH_TIMESERR;
                end else begin
                  phase_nxt = PH_IDLE;
                  len_nxt   = '0;
                  sent_nxt  = '0;
                  cnt_nxt   = '0;
                end
              end
              PH_TIMESERR: begin
                emit                   = 1'b1;
                emit_res.kind          = KIND_TIMES;
                emit_res.slave_address = req0_r;
                emit_res.function_code = req1_r;
                emit_res.last_out      = 1'b1;
                emit_res.machine_state = PH_IDLE;
                err_nxt   = 8'd0;
                phase_nxt = PH_IDLE;
                len_nxt   = '0;
                sent_nxt  = '0;
                cnt_nxt   = '0;
              end
              PH_EXEC: begin
                if (fc_data && cnt_r > CW'(2)) begin
                  k_nxt    = CW'(2);
                  kend_nxt = cnt_r;
                  seq_nxt  = SQ_DLVRD;
                end
                phase_nxt = PH_IDLE;
                len_nxt   = '0;
                sent_nxt  = '0;
                cnt_nxt   = '0;
              end
              default: begin
              end
            endcase
          end
        end
      end
      SQ_CRCLO: begin
        // CRC low byte follows the request.
        req_we    = 1'b1;
        req_wdata = crc_r[7:0];
        len_nxt   = len_r + CW'(1);
        seq_nxt   = SQ_CRCHI;
      end
      SQ_CRCHI: begin
        // CRC high byte, then the first frame byte goes out.
        if (out_free) begin
          req_we                 = 1'b1;
          req_wdata              = crc_r[15:8];
          len_nxt                = len_r + CW'(1);
          phase_nxt              = PH_TX;
          sent_nxt               = CW'(1);
          cnt_nxt                = '0;
          emit                   = 1'b1;
          emit_res.kind          = KIND_TX;
          emit_res.out_byte      = req0_r;
          emit_res.last_out      = 1'b1;
          emit_res.machine_state = PH_TX;
          seq_nxt                = SQ_IDLE;
        end
      end
      SQ_TXRD: begin
        seq_nxt = SQ_TXOUT;
      end
      SQ_TXOUT: begin
        if (out_free) begin
          emit                   = 1'b1;
          emit_res.kind          = KIND_TX;
          emit_res.out_byte      = req_rd_r;
          emit_res.last_out      = 1'b1;
          emit_res.machine_state = phase_r;
          sent_nxt               = sent_r + CW'(1);
          seq_nxt                = SQ_IDLE;
        end
      end
      SQ_DLVRD: begin
        seq_nxt = SQ_DLVOUT;
      end
      SQ_DLVOUT: begin
        // One reply data byte per pass.
        if (out_free) begin
          emit                   = 1'b1;
          emit_res.kind          = KIND_DATA;
          emit_res.out_byte      = rep_rd_r;
          emit_res.slave_address = rep0_r;
          emit_res.function_code = rep1_r;
          emit_res.last_out      = (k_r + CW'(1) == kend_r);
          emit_res.machine_state = PH_IDLE;
          k_nxt                  = k_r + CW'(1);
          seq_nxt                = (k_r + CW'(1) == kend_r) ? SQ_IDLE : SQ_DLVRD;
        end
      end
      default: begin
        seq_nxt = SQ_IDLE;
      end
    endcase

    // Keep copies of address and function entries for the checks.
    if (req_we && req_waddr == AW'(0)) req0_nxt = req_wdata;
    if (req_we && req_waddr == AW'(1)) req1_nxt = req_wdata;
    if (rep_we && rep_waddr == AW'(0)) rep0_nxt = rep_wdata;
    if (rep_we && rep_waddr == AW'(1)) rep1_nxt = rep_wdata;
  end

  // Result register.
  always_comb begin
    out_vld_nxt = emit ? 1'b1 : (out_stall ? out_vld_r : 1'b0);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      seq_r     <= SQ_IDLE;
      phase_r   <= PH_IDLE;
      len_r     <= '0;
      sent_r    <= '0;
      cnt_r     <= '0;
      k_r       <= '0;
      kend_r    <= '0;
      crc_r     <= CRC_INIT;
      err_r     <= 8'd0;
      wait_r    <= 8'd0;
      out_vld_r <= 1'b0;
    end else begin
      seq_r     <= seq_nxt;
      phase_r   <= phase_nxt;
      len_r     <= len_nxt;
      sent_r    <= sent_nxt;
      cnt_r     <= cnt_nxt;
      k_r       <= k_nxt;
      kend_r    <= kend_nxt;
      crc_r     <= crc_nxt;
      err_r     <= err_nxt;
      wait_r    <= wait_nxt;
      out_vld_r <= out_vld_nxt;
    end
  end

  // Payload registers.
  always_ff @(posedge clk) begin
    req0_r <= req0_nxt;
    req1_r <= req1_nxt;
    rep0_r <= rep0_nxt;
    rep1_r <= rep1_nxt;
    if (emit) begin
      out_res_r <= emit_res;
    end
  end

  // Request frame store.
  always_ff @(posedge clk) begin
    if (req_we) begin
      req_mem[req_waddr] <= req_wdata;
    end
    req_rd_r <= req_mem[sent_r[AW-1:0]];
  end

  // Reply frame store.
  always_ff @(posedge clk) begin
    if (rep_we) begin
      rep_mem[rep_waddr] <= rep_wdata;
    end
    rep_rd_r <= rep_mem[k_r[AW-1:0]];
  end

endmodule

@@ sv/modbus_rtu_master_transaction.sv @@
// Top level of the Modbus RTU master: configuration registers, front end and back end.
//
// Requests enter on the in_ channel (valid/stall) and carry an action: a request
// byte, transmitter ready, received byte, character timer tick or poll. Results
// leave on the out_ channel (valid/stall): bytes to transmit, busy rejects, reply
// data bytes and times-errors, the last one of each request marked by last_out.
// The front end classifies requests into a two-entry queue; the back end runs
// them one at a time. A frame end passes the CRC low and high states while the
// CRC bytes are stored, a transmitter ready that sends a byte passes a frame
// store read state before its output state, and a poll that delivers reply data
// passes a read and an output state per data byte, bound by the reply store read
// port. Each result appears in the cycle after the back-end cycle that forms it.
// A stalled result holds in the output register; the back end then waits, the
// queue fills and in_stall rises. Reset returns the block to idle with the
// registers at their defaults; no clearing pass is needed. The user is to write
// registers over the APB port only while the block is idle; this is not enforced.
`include "modbus_rtu_master_transaction_defines.svh"

module modbus_rtu_master_transaction
  import mbm_pkg::*;
#(
  parameter int MAX_FRAME = 64
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [2:0]  in_action,
  input  logic [7:0]  in_byte_value,
  input  logic        in_frame_end,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [2:0]  out_kind,
  output logic [7:0]  out_out_byte,
  output logic [7:0]  out_slave_address,
  output logic [7:0]  out_function_code,
  output logic        out_last_out,
  output logic [2:0]  out_machine_state,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [3:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);

  cfg_t  cfg_r;
  logic  cfg_wr;
  logic  q_valid, q_pop;
  item_t q_item;
  res_t  res;

  // Configuration registers.
  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite && pready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.timeout   <= 8'd20;
      cfg_r.err_limit <= 8'd3;
      cfg_r.min_bytes <= 7'd4;
    end else if (cfg_wr) begin
      case (paddr[3:2])
        REG_TIMEOUT:   cfg_r.timeout   <= pwdata[7:0];
        REG_ERR_LIMIT: cfg_r.err_limit <= pwdata[7:0];
        REG_MIN_BYTES: cfg_r.min_bytes <= pwdata[6:0];
        default: begin
        end
      endcase
    end
  end

  // Register read-back.
  always_comb begin
    case (paddr[3:2])
      REG_TIMEOUT:   prdata = {24'd0, cfg_r.timeout};
      REG_ERR_LIMIT: prdata = {24'd0, cfg_r.err_limit};
      REG_MIN_BYTES: prdata = {25'd0, cfg_r.min_bytes};
      default:       prdata = 32'd0;
    endcase
  end

  mbm_front u_front (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_valid      (in_valid),
    .in_stall      (in_stall),
    .in_action     (in_action),
    .in_byte_value (in_byte_value),
    .in_frame_end  (in_frame_end),
    .q_valid       (q_valid),
    .q_item        (q_item),
    .q_pop         (q_pop)
  );

  mbm_back #(
    .MAX_FRAME (MAX_FRAME)
  ) u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg       (cfg_r),
    .q_valid   (q_valid),
    .q_item    (q_item),
    .q_pop     (q_pop),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_res   (res)
  );

  // Result ports.
  assign out_kind          = res.kind;
  assign out_out_byte      = res.out_byte;
  assign out_slave_address = res.slave_address;
  assign out_function_code = res.function_code;
  assign out_last_out      = res.last_out;
  assign out_machine_state = res.machine_state;

  // A busy reject is always the only result of its request.
  `MBM_ASSERT_NOW(a_busy_alone, clk, rst_n, out_valid && out_kind == KIND_BUSY, out_last_out)
  // Transmit bytes only leave while the frame is being sent.
  `MBM_ASSERT_NOW(a_tx_phase, clk, rst_n, out_valid && out_kind == KIND_TX,
                  out_machine_state == PH_TX)
  // Reply data and times-errors leave the block idle.
  `MBM_ASSERT_NOW(a_done_idle, clk, rst_n,
                  out_valid && (out_kind == KIND_DATA || out_kind == KIND_TIMES),
                  out_machine_state == PH_IDLE)
  // The queue never pops while a result is stuck in the output register.
  `MBM_ASSERT_NOW(a_pop_free, clk, rst_n, q_pop, !(out_valid && out_stall))

endmodule

@@ tb/testbench.sv @@
// Self-checking testbench for the Modbus RTU master transaction block.
module testbench;
  import mbm_pkg::*;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_valid = 1'b0;
  logic        in_stall;
  logic [2:0]  in_action = ACT_POLL;
  logic [7:0]  in_byte_value = 8'h00;
  logic        in_frame_end = 1'b0;
  logic        out_valid;
  logic        out_stall = 1'b0;
  logic [2:0]  out_kind;
  logic [7:0]  out_out_byte;
  logic [7:0]  out_slave_address;
  logic [7:0]  out_function_code;
  logic        out_last_out;
  logic [2:0]  out_machine_state;
  logic        psel = 1'b0;
  logic        penable = 1'b0;
  logic        pwrite = 1'b0;
  logic [3:0]  paddr = 4'd0;
  logic [31:0] pwdata = 32'd0;
  logic [31:0] prdata;
  logic        pready;

  modbus_rtu_master_transaction i_dut (.*);

  always #2 clk = ~clk;

  // Mirror of the transaction engine state.
  logic [2:0]  ph;
  logic [7:0]  req_bytes [64];
  logic [7:0]  rep_bytes [64];
  int          req_len, sent_cnt, rep_cnt, err_cnt, idle_ticks;
  logic [15:0] crc;
  cfg_t        cfg;

  res_t        expected_results [$];
  int          errors = 0;
  int          cycles = 0;
  int          result_cnt = 0;
  int          data_cnt = 0;
  int          transactions = 0;
  int          item_cnt = 0;
  int          stall_left = 0;
  logic [2:0]  first_kind;
  int          new_results;

  function automatic logic [15:0] crc16_step(logic [15:0] c, logic [7:0] b);
    logic [15:0] r;
    r = c ^ {8'h00, b};
    repeat (8) r = r[0] ? ((r >> 1) ^ 16'hA001) : (r >> 1);
    return r;
  endfunction

  // Compute the results one request causes and queue them.
  task automatic predict(input logic [2:0] act, input logic [7:0] b, input logic fe);
    res_t r;
    res_t batch [$];
    logic ok;
    logic [7:0] fc;
    case (act)
      ACT_REQ_BYTE: begin
        if (ph != PH_IDLE) begin
          r = '0; r.kind = KIND_BUSY; batch.push_back(r);
        end else begin
          if (req_len == 0) crc = CRC_INIT;
          if (req_len < 62) begin
            req_bytes[req_len] = b; req_len++; crc = crc16_step(crc, b);
          end
          if (fe) begin
            req_bytes[req_len] = crc[7:0];
            req_bytes[req_len+1] = crc[15:8];
            req_len += 2;
            rep_cnt = 0;
            ph = PH_TX;
            r = '0; r.kind = KIND_TX; r.out_byte = req_bytes[0]; batch.push_back(r);
            sent_cnt = 1;
          end
        end
      end
      ACT_TX_READY: begin
        if (ph == PH_TX) begin
          if (sent_cnt >= req_len) begin
            ph = PH_TXDONE; idle_ticks = 0;
          end else begin
            r = '0; r.kind = KIND_TX; r.out_byte = req_bytes[sent_cnt];
            batch.push_back(r);
            sent_cnt++;
          end
        end
      end
      ACT_RX_BYTE: begin
        if (ph == PH_TXDONE) begin
          rep_bytes[0] = b; rep_cnt = 1; crc = crc16_step(CRC_INIT, b); ph = PH_RX;
        end else if (ph == PH_RX && rep_cnt < 64) begin
          rep_bytes[rep_cnt] = b; rep_cnt++; crc = crc16_step(crc, b);
        end
      end
      ACT_TICK: begin
        if (ph == PH_TXDONE) begin
          idle_ticks++;
          if (idle_ticks >= cfg.timeout) begin
            idle_ticks = 0; ph = PH_RXERR;
          end
        end else if (ph == PH_RX) begin
          ph = PH_CHECK;
        end
      end
      ACT_POLL: begin
        case (ph)
          PH_CHECK: begin
            ok = rep_cnt >= 2 && rep_cnt >= cfg.min_bytes && crc == 16'h0000;
            if (ok) ok = rep_bytes[0] == req_bytes[0] && rep_bytes[1] == req_bytes[1];
            ph = ok ? PH_EXEC : PH_RXERR;
          end
          PH_RXERR: begin
            if (err_cnt < 255) err_cnt++;
            if (err_cnt >= cfg.err_limit) ph = PH_TIMESERR;
            else begin
              ph = PH_IDLE; req_len = 0; sent_cnt = 0; rep_cnt = 0;
            end
          end
          PH_TIMESERR: begin
            r = '0; r.kind = KIND_TIMES; r.slave_address = req_bytes[0];
            r.function_code = req_bytes[1];
            batch.push_back(r);
            err_cnt = 0;
            ph = PH_IDLE; req_len = 0; sent_cnt = 0; rep_cnt = 0;
          end
          PH_EXEC: begin
            fc = rep_bytes[1];
            if ((fc >= 1 && fc <= 6) || fc == FC_MULTI_COILS || fc == FC_MULTI_REGS)
              for (int k = 2; k < rep_cnt; k++) begin
                r = '0; r.kind = KIND_DATA; r.out_byte = rep_bytes[k];
                r.slave_address = rep_bytes[0]; r.function_code = fc;
                batch.push_back(r);
              end
            ph = PH_IDLE; req_len = 0; sent_cnt = 0; rep_cnt = 0;
          end
          default: ;
        endcase
      end
      default: ;
    endcase
    // Stamp the closing phase and the last-result marker.
    foreach (batch[i]) begin
      batch[i].machine_state = ph;
      batch[i].last_out = (i == batch.size() - 1);
      expected_results.push_back(batch[i]);
    end
    new_results = batch.size();
    first_kind = batch.size() ? batch[0].kind : KIND_NONE;
  endtask

  // Drive one request with a random lead-in gap, then wait for acceptance.
  task automatic send(input logic [2:0] act, input logic [7:0] b, input logic fe);
    int gap;
    gap = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(0, 17);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_action <= act;
    in_byte_value <= b;
    in_frame_end <= fe;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    predict(act, b, fe);
    item_cnt++;
  endtask

  task automatic drain();
    in_valid <= 1'b0;
    @(posedge clk);
    while (expected_results.size() != 0) @(posedge clk);
    repeat (12) @(posedge clk);
  endtask

  // APB write, setup then access; the register lands on the access cycle.
  task automatic write_reg(input logic [1:0] idx, input logic [7:0] v);
    psel <= 1'b1; pwrite <= 1'b1; penable <= 1'b0;
    paddr <= {idx, 2'b00}; pwdata <= {24'd0, v};
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    psel <= 1'b0; penable <= 1'b0; pwrite <= 1'b0;
    case (idx)
      REG_TIMEOUT:   cfg.timeout = v;
      REG_ERR_LIMIT: cfg.err_limit = v;
      default:       cfg.min_bytes = v[6:0];
    endcase
  endtask

  // One full exchange: request, transmission, reply and polls.
  task automatic exchange();
    logic [7:0] addr, fc, v;
    logic [15:0] c;
    int n_req, n_data, mode, guard;
    logic [7:0] reply [$];
    addr = 8'($urandom_range(0, 255));
    case ($urandom_range(0, 3))
      0: fc = 8'($urandom_range(0, 255));
      1: fc = $urandom_range(0, 1) ? FC_MULTI_COILS : FC_MULTI_REGS;
      default: fc = 8'($urandom_range(1, 6));
    endcase
    n_req = ($urandom_range(0, 19) == 0) ? $urandom_range(60, 70) : $urandom_range(1, 8);
    for (int i = 0; i < n_req; i++) begin
      v = (i == 0) ? addr : (i == 1) ? fc : 8'($urandom_range(0, 255));
      send(ACT_REQ_BYTE, v, i == n_req - 1);
    end
    if (n_req == 1) fc = req_bytes[1];
    guard = 0;
    while (ph == PH_TX && guard < 80) begin
      if ($urandom_range(0, 15) == 0)
        send(ACT_REQ_BYTE, 8'($urandom_range(0, 255)), 1'b1);
      send(ACT_TX_READY, 8'h00, 1'b0);
      guard++;
    end
    // Reply: mostly well formed, sometimes corrupted, short or absent.
    mode = $urandom_range(0, 9);
    n_data = ($urandom_range(0, 24) == 0) ? $urandom_range(50, 70) : $urandom_range(0, 6);
    reply.push_back(mode == 6 ? addr ^ 8'h01 : addr);
    reply.push_back(fc);
    repeat (n_data) reply.push_back(8'($urandom_range(0, 255)));
    c = CRC_INIT;
    foreach (reply[i]) c = crc16_step(c, reply[i]);
    reply.push_back(c[7:0]);
    reply.push_back(c[15:8]);
    if (mode == 7) reply[reply.size() - 1] ^= 8'h80;
    if (mode == 8) reply = '{addr};
    if (mode != 9)
      foreach (reply[i]) send(ACT_RX_BYTE, reply[i], 1'b0);
    guard = 0;
    while ((ph == PH_TXDONE || ph == PH_RX) && guard < 300) begin
      send(ACT_TICK, 8'h00, 1'b0);
      guard++;
    end
    guard = 0;
    while (ph != PH_IDLE && guard < 10) begin
      send(ACT_POLL, 8'h00, 1'b0);
      guard++;
    end
    transactions++;
  endtask

  // Result side: random stall per result, field-by-field comparison.
  always @(posedge clk) begin
    if (rst_n && out_valid && !out_stall) begin
      if (expected_results.size() == 0) begin
        $error("unexpected result kind=%0d", out_kind);
        errors++;
      end else begin
        res_t e;
        e = expected_results.pop_front();
        if (out_kind !== e.kind) begin
          $error("kind: expected %0d, got %0d", e.kind, out_kind); errors++;
        end
        if (out_out_byte !== e.out_byte) begin
          $error("out_byte: expected %0h, got %0h", e.out_byte, out_out_byte); errors++;
        end
        if (out_slave_address !== e.slave_address) begin
          $error("slave_address: expected %0h, got %0h", e.slave_address,
                 out_slave_address);
          errors++;
        end
        if (out_function_code !== e.function_code) begin
          $error("function_code: expected %0h, got %0h", e.function_code,
                 out_function_code);
          errors++;
        end
        if (out_last_out !== e.last_out) begin
          $error("last_out: expected %0d, got %0d", e.last_out, out_last_out); errors++;
        end
        if (out_machine_state !== e.machine_state) begin
          $error("machine_state: expected %0d, got %0d", e.machine_state,
                 out_machine_state);
          errors++;
        end
        if (e.kind == KIND_DATA) data_cnt++;
      end
      result_cnt++;
      stall_left = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(0, 17);
    end
    if (stall_left > 0) begin
      out_stall <= 1'b1;
      stall_left--;
    end else begin
      out_stall <= 1'b0;
    end
  end

  // Watchdog on the whole run.
  always @(posedge clk) begin
    cycles++;
    if (cycles > 3000000) begin
      $display("*** FAILED ***");
      $finish;
    end
  end

  typedef struct {
    logic [2:0] act;
    logic [7:0] b;
    logic       fe;
    logic [2:0] want_kind;  // KIND_NONE: checked by the predictor alone
  } row_t;

  // Directed opening: one-byte frame with byte extremes, busy reject,
  // a rejected short reply, an unanswered request and idle noise.
  row_t rows [] = '{
    '{ACT_POLL,     8'h00, 1'b0, KIND_NONE},
    '{ACT_REQ_BYTE, 8'hFF, 1'b1, KIND_TX},
    '{ACT_REQ_BYTE, 8'h00, 1'b0, KIND_BUSY},
    '{ACT_TX_READY, 8'h00, 1'b0, KIND_TX},
    '{ACT_TX_READY, 8'h00, 1'b0, KIND_TX},
    '{ACT_TX_READY, 8'h00, 1'b0, KIND_NONE},
    '{ACT_RX_BYTE,  8'hFF, 1'b0, KIND_NONE},
    '{ACT_RX_BYTE,  8'h00, 1'b0, KIND_NONE},
    '{ACT_TICK,     8'h00, 1'b0, KIND_NONE},
    '{ACT_POLL,     8'h00, 1'b0, KIND_NONE},
    '{ACT_POLL,     8'h00, 1'b0, KIND_NONE},
    '{3'd5,         8'hAA, 1'b1, KIND_NONE},
    '{3'd7,         8'h55, 1'b0, KIND_NONE},
    '{ACT_REQ_BYTE, 8'h01, 1'b0, KIND_NONE},
    '{ACT_REQ_BYTE, 8'h03, 1'b1, KIND_TX},
    '{ACT_TX_READY, 8'h00, 1'b0, KIND_TX},
    '{ACT_TX_READY, 8'h00, 1'b0, KIND_TX},
    '{ACT_TX_READY, 8'h00, 1'b0, KIND_TX},
    '{ACT_TX_READY, 8'h00, 1'b0, KIND_NONE},
    '{ACT_TICK,     8'h00, 1'b0, KIND_NONE},
    '{3'd6,         8'h00, 1'b0, KIND_NONE}
  };

  initial begin
    logic [7:0] settings [5][3];
    ph = PH_IDLE; req_len = 0; sent_cnt = 0; rep_cnt = 0; err_cnt = 0;
    idle_ticks = 0; crc = CRC_INIT;
    cfg.timeout = 8'd20; cfg.err_limit = 8'd3; cfg.min_bytes = 7'd4;
    foreach (req_bytes[i]) begin
      req_bytes[i] = '0; rep_bytes[i] = '0;
    end
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    foreach (rows[i]) begin
      send(rows[i].act, rows[i].b, rows[i].fe);
      if (rows[i].want_kind != KIND_NONE && first_kind != rows[i].want_kind) begin
        $error("directed row %0d kind: expected %0d, predicted %0d", i,
               rows[i].want_kind, first_kind);
        errors++;
      end
    end
    drain();

    settings = '{'{8'd1, 8'd1, 8'd4}, '{8'd255, 8'd255, 8'd64}, '{8'd3, 8'd2, 8'd6},
                 '{8'd20, 8'd3, 8'd4}, '{8'd0, 8'd0, 8'd0}};
    settings[4][0] = 8'($urandom_range(1, 30));
    settings[4][1] = 8'($urandom_range(1, 5));
    settings[4][2] = 8'($urandom_range(4, 10));
    foreach (settings[s]) begin
      write_reg(REG_TIMEOUT, settings[s][0]);
      write_reg(REG_ERR_LIMIT, settings[s][1]);
      write_reg(REG_MIN_BYTES, settings[s][2]);
      while (item_cnt < 100 * (s + 1)) begin
        if ($urandom_range(0, 7) == 0)
          send(3'($urandom_range(0, 7)), 8'($urandom_range(0, 255)),
               1'($urandom_range(0, 1)));
        else
          exchange();
      end
      drain();
    end

    $display("Ran %0d requests in %0d exchanges over five register settings.",
             item_cnt, transactions);
    $display("Checked %0d results, %0d of them reply data bytes.", result_cnt, data_cnt);
    if (errors == 0 && expected_results.size() == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end
endmodule

@@ filelist.f @@
+incdir+sv
sv/mbm_pkg.sv
sv/mbm_front.sv
sv/mbm_back.sv
sv/modbus_rtu_master_transaction.sv
tb/testbench.sv
